### rtl/core/fll_alarm_pkg.sv
// ---------------------------------------------------------------------------
// fll_alarm_pkg: shared types and constants of the four-level limit alarm
// Item structs, register indexes, alarm bit positions and the hysteresis
// divider constants.
// ---------------------------------------------------------------------------
package fll_alarm_pkg;

  localparam int unsigned DataWidth     = 32;
  localparam int unsigned PermilleWidth = 10;
  localparam int unsigned EnableWidth   = 8;
  localparam int unsigned AlarmCount    = 6;
  localparam int unsigned CfgIndexWidth = 3;

  // hysteresis = floor(span * permille / HystDivisor)
  localparam int unsigned HystDivisor   = 1000;
  localparam int unsigned RemWidth      = $clog2(HystDivisor);
  localparam int unsigned HystWidth     = DataWidth + 1;
  // divide by 1000 as a shift by 3, then multiply by 2^36 / 125 rounded up,
  // exact for operands below 2^29
  localparam int unsigned DivShift      = 3;
  localparam int unsigned RecipShift    = 36;
  localparam int unsigned RecipWidth    = 30;
  localparam logic [RecipWidth-1:0] Recip125 = 30'd549755814;
  localparam int unsigned SpanRecipWidth = DataWidth - DivShift + RecipWidth;
  localparam int unsigned QuotWidth     = SpanRecipWidth - RecipShift;
  // remainder of span times permille, below 1000 * 1024
  localparam int unsigned FracWidth     = 2 * PermilleWidth;
  localparam int unsigned FracRecipWidth = FracWidth - DivShift + RecipWidth;
  // limit +/- hysteresis, sign bit and one carry bit on top
  localparam int unsigned BoundWidth    = HystWidth + 2;

  // register indexes on the configuration port
  localparam logic [CfgIndexWidth-1:0] RegRangeMax  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegRangeMin  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegHighHigh  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegHigh      = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegLow       = 3'd4;
  localparam logic [CfgIndexWidth-1:0] RegLowLow    = 3'd5;
  localparam logic [CfgIndexWidth-1:0] RegHystPm    = 3'd6;
  localparam logic [CfgIndexWidth-1:0] RegEnable    = 3'd7;

  // alarm bit positions, also used in enable_bits
  localparam int unsigned BitHighHigh = 0;
  localparam int unsigned BitHigh     = 1;
  localparam int unsigned BitLow      = 2;
  localparam int unsigned BitLowLow   = 3;
  localparam int unsigned BitOver     = 4;
  localparam int unsigned BitUnder    = 5;
  localparam int unsigned BitGlobal   = 6;
  localparam int unsigned BitService  = 7;

  localparam logic [EnableWidth-1:0] EnableReset = 8'd64;

  typedef struct packed {
    logic signed [DataWidth-1:0] sample;
    logic                        ack;
  } in_item_t;

  typedef struct packed {
    logic                  high_high_active;
    logic                  high_active;
    logic                  low_active;
    logic                  low_low_active;
    logic                  over_range;
    logic                  under_range;
    logic [AlarmCount-1:0] raised_mask;
    logic [AlarmCount-1:0] cleared_mask;
    logic                  acknowledged;
  } out_item_t;

endpackage

### rtl/core/four_level_limit_alarm_top.sv
// ---------------------------------------------------------------------------
// four_level_limit_alarm_top: hh/h/l/ll limit alarm with hysteresis
// Limit alarms with hysteresis, over/under-range flags and an acknowledge
// latch, one result item for each sample item.
// ---------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, in_data          | sink
//  out     | out_valid, out_ready, out_data       | source
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | sink
//
//  one item per cycle: input register, one pass of compare logic, result
//  register; an item waits in the input register while the result is stalled.
//  after reset and after every configuration write the hysteresis width is
//  recomputed (span quotient by reciprocal multiply, remainder, remainder
//  product, final sum), during which in_ready is low.
//  cfg_ready is always high.
//  reset clears the alarm flags, sets the acknowledged flag and restores the
//  register defaults.
// ---------------------------------------------------------------------------
module four_level_limit_alarm_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  fll_alarm_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output fll_alarm_pkg::out_item_t                out_data,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [fll_alarm_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [fll_alarm_pkg::DataWidth-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_QUOT,
    DIV_REM,
    DIV_FRAC,
    DIV_SUM
  } div_state_t;

  // configuration registers
  logic signed [fll_alarm_pkg::DataWidth-1:0]     range_max;
  logic signed [fll_alarm_pkg::DataWidth-1:0]     range_min;
  logic signed [fll_alarm_pkg::DataWidth-1:0]     limit [4];
  logic [fll_alarm_pkg::PermilleWidth-1:0]        hyst_permille;
  logic [fll_alarm_pkg::EnableWidth-1:0]          enable_bits;

  // hysteresis width
  div_state_t                                     div_state;
  logic [fll_alarm_pkg::DataWidth-1:0]            span;
  logic [fll_alarm_pkg::SpanRecipWidth-1:0]       span_recip;
  logic [fll_alarm_pkg::QuotWidth-1:0]            span_quot;
  logic [fll_alarm_pkg::DataWidth-1:0]            quot_scaled;
  logic [fll_alarm_pkg::RemWidth-1:0]             span_rem;
  logic [fll_alarm_pkg::RemWidth-1:0]             rem_next;
  logic [fll_alarm_pkg::HystWidth-1:0]            hyst_hi;
  logic [fll_alarm_pkg::HystWidth-1:0]            hyst_hi_next;
  logic [fll_alarm_pkg::FracWidth-1:0]            frac_prod;
  logic [fll_alarm_pkg::FracWidth-1:0]            frac_next;
  logic [fll_alarm_pkg::FracRecipWidth-1:0]       frac_recip;
  logic [fll_alarm_pkg::HystWidth-1:0]            hyst;

  // item path
  logic                                           in_full;
  fll_alarm_pkg::in_item_t                        held;
  logic                                           advance;
  logic [fll_alarm_pkg::AlarmCount-1:0]           flags;
  logic                                           acked;
  logic [fll_alarm_pkg::AlarmCount-1:0]           flags_next;
  logic [fll_alarm_pkg::AlarmCount-1:0]           raised;
  logic [fll_alarm_pkg::AlarmCount-1:0]           cleared;
  logic                                           acked_next;
  logic                                           eval_on;
  logic signed [fll_alarm_pkg::BoundWidth-1:0]    pv_wide;
  logic signed [fll_alarm_pkg::BoundWidth-1:0]    hyst_wide;
  logic signed [fll_alarm_pkg::BoundWidth-1:0]    lim_wide;
  logic                                           en_on;
  logic                                           lim_in_range;
  logic                                           trip;
  logic                                           rel;
  logic                                           outside;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = (div_state == DIV_IDLE) && (!in_full || advance);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_max     <= '0;
      range_min     <= '0;
      limit[0]      <= {1'b0, {(fll_alarm_pkg::DataWidth-1){1'b1}}};
      limit[1]      <= {1'b0, {(fll_alarm_pkg::DataWidth-1){1'b1}}};
      limit[2]      <= {1'b1, {(fll_alarm_pkg::DataWidth-1){1'b0}}};
      limit[3]      <= {1'b1, {(fll_alarm_pkg::DataWidth-1){1'b0}}};
      hyst_permille <= '0;
      enable_bits   <= fll_alarm_pkg::EnableReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fll_alarm_pkg::RegRangeMax: range_max <= cfg_data;
        fll_alarm_pkg::RegRangeMin: range_min <= cfg_data;
        fll_alarm_pkg::RegHighHigh: limit[0]  <= cfg_data;
        fll_alarm_pkg::RegHigh:     limit[1]  <= cfg_data;
        fll_alarm_pkg::RegLow:      limit[2]  <= cfg_data;
        fll_alarm_pkg::RegLowLow:   limit[3]  <= cfg_data;
        fll_alarm_pkg::RegHystPm:
          hyst_permille <= cfg_data[fll_alarm_pkg::PermilleWidth-1:0];
        fll_alarm_pkg::RegEnable:
          enable_bits <= cfg_data[fll_alarm_pkg::EnableWidth-1:0];
        default: ;
      endcase
    end
  end

  // span only matters when range_max > range_min, then it fits 32 bits
  assign span = range_max - range_min;

  // span = q * 1000 + r, so span * p / 1000 = q * p + floor(r * p / 1000)
  assign span_recip =
      fll_alarm_pkg::SpanRecipWidth'(span[fll_alarm_pkg::DataWidth-1:fll_alarm_pkg::DivShift])
    * fll_alarm_pkg::SpanRecipWidth'(fll_alarm_pkg::Recip125);
  assign quot_scaled  = fll_alarm_pkg::DataWidth'(span_quot)
                      * fll_alarm_pkg::DataWidth'(fll_alarm_pkg::HystDivisor);
  assign rem_next     = fll_alarm_pkg::RemWidth'(span - quot_scaled);
  assign hyst_hi_next = fll_alarm_pkg::HystWidth'(span_quot)
                      * fll_alarm_pkg::HystWidth'(hyst_permille);
  assign frac_next    = fll_alarm_pkg::FracWidth'(span_rem)
                      * fll_alarm_pkg::FracWidth'(hyst_permille);
  assign frac_recip =
      fll_alarm_pkg::FracRecipWidth'(frac_prod[fll_alarm_pkg::FracWidth-1:fll_alarm_pkg::DivShift])
    * fll_alarm_pkg::FracRecipWidth'(fll_alarm_pkg::Recip125);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_state <= DIV_QUOT;
    end else if (cfg_valid && cfg_ready) begin
      div_state <= DIV_QUOT;
    end else begin
      case (div_state)
        DIV_QUOT: begin
          span_quot <= span_recip[fll_alarm_pkg::SpanRecipWidth-1:fll_alarm_pkg::RecipShift];
          div_state <= DIV_REM;
        end
        DIV_REM: begin
          span_rem  <= rem_next;
          hyst_hi   <= hyst_hi_next;
          div_state <= DIV_FRAC;
        end
        DIV_FRAC: begin
          frac_prod <= frac_next;
          div_state <= DIV_SUM;
        end
        DIV_SUM: begin
          hyst <= hyst_hi + fll_alarm_pkg::HystWidth'(
                    frac_recip[fll_alarm_pkg::FracRecipWidth-1:fll_alarm_pkg::RecipShift]);
          div_state <= DIV_IDLE;
        end
        default: ;
      endcase
    end
  end

  // alarm evaluation for the held item
  always_comb begin
    flags_next   = flags;
    raised       = '0;
    cleared      = '0;
    eval_on      = !enable_bits[fll_alarm_pkg::BitService] && (range_max > range_min);
    pv_wide      = fll_alarm_pkg::BoundWidth'(held.sample);
    hyst_wide    = $signed({2'b00, hyst});
    en_on        = 1'b0;
    lim_in_range = 1'b0;
    trip         = 1'b0;
    rel          = 1'b0;
    lim_wide     = '0;
    outside      = 1'b0;
    if (eval_on) begin
      for (int b = 0; b < 4; b++) begin
        en_on        = enable_bits[b] && enable_bits[fll_alarm_pkg::BitGlobal];
        lim_in_range = (limit[b] > range_min) && (limit[b] < range_max);
        lim_wide     = fll_alarm_pkg::BoundWidth'(limit[b]);
        // high-side alarms are the first two
        if (b < 2) begin
          trip = held.sample >= limit[b];
          rel  = pv_wide < (lim_wide - hyst_wide);
        end else begin
          trip = held.sample <= limit[b];
          rel  = pv_wide > (lim_wide + hyst_wide);
        end
        if (!en_on) begin
          flags_next[b] = 1'b0;
        end else if (lim_in_range) begin
          if (trip) begin
            raised[b]     = !flags[b];
            flags_next[b] = 1'b1;
          end else if (rel) begin
            cleared[b]    = flags[b];
            flags_next[b] = 1'b0;
          end
        end
      end
      for (int b = fll_alarm_pkg::BitOver; b <= fll_alarm_pkg::BitUnder; b++) begin
        outside = (b == fll_alarm_pkg::BitOver) ? (held.sample > range_max)
                                                : (held.sample < range_min);
        if (!enable_bits[b]) begin
          flags_next[b] = 1'b0;
        end else if (outside) begin
          raised[b]     = !flags[b];
          flags_next[b] = 1'b1;
        end else begin
          cleared[b]    = flags[b];
          flags_next[b] = 1'b0;
        end
      end
    end
    // ack wins over a raise in the same item
    acked_next = held.ack ? 1'b1 : ((raised != '0) ? 1'b0 : acked);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      flags     <= '0;
      acked     <= 1'b1;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        flags     <= flags_next;
        acked     <= acked_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_data;
    end
    if (advance) begin
      out_data.high_high_active <= flags_next[fll_alarm_pkg::BitHighHigh];
      out_data.high_active      <= flags_next[fll_alarm_pkg::BitHigh];
      out_data.low_active       <= flags_next[fll_alarm_pkg::BitLow];
      out_data.low_low_active   <= flags_next[fll_alarm_pkg::BitLowLow];
      out_data.over_range       <= flags_next[fll_alarm_pkg::BitOver];
      out_data.under_range      <= flags_next[fll_alarm_pkg::BitUnder];
      out_data.raised_mask      <= raised;
      out_data.cleared_mask     <= cleared;
      out_data.acknowledged     <= acked_next;
    end
  end

endmodule
